// ===== rtl/stunbr_pkg.sv =====
package stunbr_pkg;

	localparam logic [31:0] STUN_COOKIE = 32'h2112_A442;
	localparam logic [15:0] CLASS_MASK  = 16'hC000;
	localparam logic [15:0] BIND_REQ    = 16'h0001;
	localparam logic [15:0] BIND_OK     = 16'h0101;
	localparam logic [15:0] XMA_TYPE    = 16'h0020;
	localparam logic [7:0]  XMA_LEN     = 8'd8;
	localparam logic [7:0]  FAMILY_V4   = 8'h01;
	localparam logic [4:0]  HDR_BYTES   = 5'd20;
	localparam logic [4:0]  RESP_LAST   = 5'd31;

	// header byte positions
	localparam logic [4:0] POS_COOKIE = 5'd4;
	localparam logic [4:0] POS_TXN    = 5'd8;

	typedef struct packed {
		logic [95:0] txn;
		logic [15:0] xport;
		logic [31:0] xip;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} jobq_stat_t;

	function automatic logic [7:0] resp_byte(input job_t job, input logic [4:0] idx);
		logic [4:0] off;
		logic [7:0] b;
		off = 5'd0;
		b = 8'h00;
		unique case (idx) inside
			5'd0:          b = BIND_OK[15:8];
			5'd1:          b = BIND_OK[7:0];
			5'd2:          b = 8'h00;
			5'd3:          b = 8'd4 + XMA_LEN;
			[5'd4:5'd7]: begin
				off = 5'd7 - idx;
				b = 8'(STUN_COOKIE >> {off[1:0], 3'b000});
			end
			[5'd8:5'd19]: begin
				off = 5'd19 - idx;
				b = 8'(job.txn >> {off[3:0], 3'b000});
			end
			5'd20:         b = XMA_TYPE[15:8];
			5'd21:         b = XMA_TYPE[7:0];
			5'd22:         b = 8'h00;
			5'd23:         b = XMA_LEN;
			5'd24:         b = 8'h00;
			5'd25:         b = FAMILY_V4;
			5'd26:         b = job.xport[15:8];
			5'd27:         b = job.xport[7:0];
			[5'd28:5'd31]: begin
				off = 5'd31 - idx;
				b = 8'(job.xip >> {off[1:0], 3'b000});
			end
			default:       b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/stun_binding_responder_core.sv =====
// STUN binding responder.
// Input queue side: one datagram byte per word (data_byte, byte_last) with the
// sender address (client_ip, client_port) sampled on the last byte. A word is
// taken when push is high and full is low; bytes go in one per cycle.
// The front captures the 20-byte header and checks it on the last byte; a
// valid binding request becomes a job in a two-entry job queue, anything
// else is dropped without output.
// Result queue side: the back turns each job into 32 response words
// (response_byte, response_last on byte 31); a word is taken when pop is high
// and empty is low. With pop held high the back gives one word per cycle,
// and loads the next job from the queue between responses.
// The job goes through the job queue and job_q before the first word loads.
// full rises while two jobs wait in the queue behind the one the back is
// sending, so a stalled receiver holds off the sender once three responses
// are pending; the next output word is loaded in the cycle the current one
// is taken.
// Reset clears the header capture, the job queue and the output valid flag.
module stun_binding_responder_core import stunbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        byte_last,
	input  logic [31:0] client_ip,
	input  logic [15:0] client_port,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  response_byte,
	output logic        response_last
);

	logic       take;
	logic       job_push;
	job_t       rx_job;
	job_t       q_job;
	logic       job_pop;
	jobq_stat_t q_stat;

	assign full = q_stat.full;
	assign take = push && !q_stat.full;

	stunbr_rx u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.byte_last  (byte_last),
		.client_ip  (client_ip),
		.client_port(client_port),
		.job_push   (job_push),
		.job        (rx_job)
	);

	stunbr_jobq u_jobq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (job_push),
		.wr_job(rx_job),
		.rd    (job_pop),
		.rd_job(q_job),
		.stat  (q_stat)
	);

	stunbr_tx u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_job        (q_job),
		.q_pop        (job_pop),
		.pop          (pop),
		.empty        (empty),
		.response_byte(response_byte),
		.response_last(response_last)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_stat.full)
		else $error("job pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !q_stat.empty)
		else $error("job popped from empty queue");

	a_stat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("job queue both full and empty");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !job_pop) |=> q_stat.full)
		else $error("job queue drained without a pop");
`endif

endmodule

// ===== rtl/stunbr_rx.sv =====
module stunbr_rx import stunbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        byte_last,
	input  logic [31:0] client_ip,
	input  logic [15:0] client_port,
	output logic        job_push,
	output job_t        job
);

	logic [4:0]  cnt_q, cnt_n;
	logic [15:0] msg_q, msg_n;
	logic [31:0] cookie_q, cookie_n;
	logic [95:0] txn_q, txn_n;
	logic        req_ok;

	always_comb begin
		cnt_n = cnt_q;
		msg_n = msg_q;
		cookie_n = cookie_q;
		txn_n = txn_q;
		if (cnt_q < HDR_BYTES) begin
			cnt_n = cnt_q + 5'd1;
			if (cnt_q < 5'd2)
				msg_n = {msg_q[7:0], data_byte};
			else if (cnt_q >= POS_COOKIE && cnt_q < POS_TXN)
				cookie_n = {cookie_q[23:0], data_byte};
			else if (cnt_q >= POS_TXN)
				txn_n = {txn_q[87:0], data_byte};
		end
	end

	assign req_ok = ((msg_n & CLASS_MASK) == 16'h0000) && (cookie_n == STUN_COOKIE) &&
		(cnt_n >= HDR_BYTES) && (msg_n == BIND_REQ);

	assign job_push  = take && byte_last && req_ok;
	assign job.txn   = txn_n;
	assign job.xport = client_port ^ STUN_COOKIE[31:16];
	assign job.xip   = client_ip ^ STUN_COOKIE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			msg_q <= '0;
			cookie_q <= '0;
			txn_q <= '0;
		end else if (take) begin
			if (byte_last) begin
				cnt_q <= '0;
				msg_q <= '0;
				cookie_q <= '0;
				txn_q <= '0;
			end else begin
				cnt_q <= cnt_n;
				msg_q <= msg_n;
				cookie_q <= cookie_n;
				txn_q <= txn_n;
			end
		end
	end

endmodule

// ===== rtl/stunbr_jobq.sv =====
module stunbr_jobq import stunbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  job_t       wr_job,
	input  logic       rd,
	output job_t       rd_job,
	output jobq_stat_t stat
);

	job_t       mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign rd_job = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wptr_q <= ~wptr_q;
			if (rd)
				rptr_q <= ~rptr_q;
			if (wr && !rd)
				cnt_q <= cnt_q + 2'd1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== rtl/stunbr_tx.sv =====
module stunbr_tx import stunbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  jobq_stat_t q_stat,
	input  job_t       q_job,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] response_byte,
	output logic       response_last
);

	logic       busy_q;
	logic [4:0] idx_q;
	job_t       job_q;
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       adv;

	assign q_pop = !busy_q && !q_stat.empty;
	// output word slot frees when empty or being taken this cycle
	assign adv = busy_q && (!out_v_q || pop);

	assign empty = !out_v_q;
	assign response_byte = out_byte_q;
	assign response_last = out_last_q;

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_job;
		if (adv) begin
			out_byte_q <= resp_byte(job_q, idx_q);
			out_last_q <= (idx_q == RESP_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (adv) begin
				idx_q <= idx_q + 5'd1;
				if (idx_q == RESP_LAST)
					busy_q <= 1'b0;
			end
			if (adv)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

endmodule
